// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/srlm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_pkg
// Widths, register indexes, reset values and state types of the level meter.
// ----------------------------------------------------------------------------
package srlm_pkg;

   localparam int MAX_FRAMES = 4096;
   localparam int SUM_W      = 43;
   localparam int CNT_W      = 13;
   localparam int DISP_W     = 17;
   localparam int LOG_W      = 35;
   localparam int STEP_W     = 6;

   localparam int DIV_STEPS  = 43;
   localparam int SQRT_STEPS = 16;
   localparam int FRAC_BITS  = 30;
   localparam int QDIV_STEPS = 16;

   // register indexes
   localparam logic [1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [1:0] CSR_DECAY      = 2'd1;
   localparam logic [1:0] CSR_BAR_MAX    = 2'd2;

   localparam logic [15:0] FULL_SCALE_RESET = 16'd10000;
   localparam logic [15:0] DECAY_RESET      = 16'd58982;
   localparam logic [5:0]  BAR_MAX_RESET    = 6'd30;

   typedef enum logic [2:0] {
      T_IDLE,
      T_START_L,
      T_WAIT_L,
      T_START_R,
      T_WAIT_R,
      T_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_DIV,
      L_SQRT,
      L_LNORM,
      L_LSQ,
      L_QDIV,
      L_UPD
   } lvl_state_type;

endpackage
`default_nettype wire

// ----- design/srlm_level.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_level
// One channel's level update: mean, root, log ratio and peak hold with decay,
// worked one step per cycle under a small sequencer.
// ----------------------------------------------------------------------------
module srlm_level (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [srlm_pkg::SUM_W-1:0]    sum,
   input  wire logic [srlm_pkg::CNT_W-1:0]    count,
   input  wire logic [15:0]                   full_scale,
   input  wire logic [15:0]                   decay,
   input  wire logic [srlm_pkg::DISP_W-1:0]   disp_in,
   output logic                               done,
   output logic [srlm_pkg::DISP_W-1:0]        disp_out
);
   import srlm_pkg::*;

   lvl_state_type state_ff, state_in;

   logic [STEP_W-1:0] cnt_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [31:0]       v_ff, r_ff, bit_ff, m_ff;
   logic [4:0]        n_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic              logsel_ff, sat_ff;
   logic [LOG_W-1:0]  lb_ff;
   logic [LOG_W:0]    qrem_ff;
   logic [15:0]       q_ff;

   // step terms
   logic [CNT_W:0]    div_t;
   logic              div_ge;
   logic [SUM_W-1:0]  quo_nx;
   logic [31:0]       sq_t;
   logic [61:0]       msq;
   logic [31:0]       msq_hi;
   logic [FRAC_BITS-1:0] frac_nx;
   logic [LOG_W-1:0]  lg;
   logic [LOG_W:0]    qd_t;
   logic              qd_ge;
   logic [16:0]       fs1, rms1;
   logic [DISP_W-1:0] norm;
   logic [32:0]       dec_prod;

   assign div_t   = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge  = div_t >= {1'b0, count};
   assign quo_nx  = {quo_ff[SUM_W-2:0], div_ge};
   assign sq_t    = r_ff + bit_ff;
   assign msq     = m_ff[30:0] * m_ff[30:0];
   assign msq_hi  = msq[61:30];
   assign frac_nx = {frac_ff[FRAC_BITS-2:0], msq_hi[31]};
   assign lg      = {n_ff, frac_nx};
   assign qd_t    = {qrem_ff[LOG_W-1:0], 1'b0};
   assign qd_ge   = qd_t >= {1'b0, lb_ff};
   // zero full scale counts as one
   assign fs1     = (full_scale == 16'd0) ? 17'd2 : {1'b0, full_scale} + 17'd1;
   assign rms1    = r_ff[16:0] + 17'd1;
   assign norm    = sat_ff ? 17'h10000 : {1'b0, q_ff};
   assign dec_prod = disp_in * decay;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE:  if (start) state_in = L_DIV;
         L_DIV:   if (cnt_ff == '0) state_in = L_SQRT;
         L_SQRT:  if (cnt_ff == '0) state_in = L_LNORM;
         L_LNORM: if (m_ff[16]) state_in = L_LSQ;
         L_LSQ: begin
            if (cnt_ff == '0) state_in = logsel_ff ? L_QDIV : L_LNORM;
         end
         L_QDIV:  if (cnt_ff == '0 || sat_ff) state_in = L_UPD;
         L_UPD:   state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done     = (state_ff == L_UPD);
      disp_out = (norm > disp_in) ? norm : dec_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= L_IDLE;
      else       state_ff <= state_in;
   end

   // datapath steps
   always_ff @(posedge clock) begin
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               quo_ff <= sum;
               rem_ff <= '0;
               cnt_ff <= STEP_W'(DIV_STEPS - 1);
            end
         end
         // restoring divide, one quotient bit a cycle
         L_DIV: begin
            rem_ff <= div_ge ? CNT_W'(div_t - {1'b0, count}) : div_t[CNT_W-1:0];
            quo_ff <= quo_nx;
            if (cnt_ff == '0) begin
               v_ff      <= (count == '0) ? 32'd0 : {1'b0, quo_nx[30:0]};
               r_ff      <= '0;
               bit_ff    <= 32'h4000_0000;
               cnt_ff    <= STEP_W'(SQRT_STEPS - 1);
               logsel_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         // bitwise square root, two radicand bits a cycle
         L_SQRT: begin
            if (v_ff >= sq_t) begin
               v_ff <= v_ff - sq_t;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               m_ff <= {15'd0, fs1};
               n_ff <= 5'd16;
            end
         end
         // find leading one, then form the Q1.30 mantissa
         L_LNORM: begin
            if (!m_ff[16]) begin
               m_ff <= m_ff << 1;
               n_ff <= n_ff - 1'b1;
            end else begin
               m_ff    <= {1'b0, m_ff[16:0], 14'd0};
               frac_ff <= '0;
               cnt_ff  <= STEP_W'(FRAC_BITS - 1);
            end
         end
         // one fraction bit per squaring
         L_LSQ: begin
            frac_ff <= frac_nx;
            if (cnt_ff != '0) begin
               m_ff   <= msq_hi[31] ? (msq_hi >> 1) : msq_hi;
               cnt_ff <= cnt_ff - 1'b1;
            end else if (!logsel_ff) begin
               lb_ff     <= lg;
               logsel_ff <= 1'b1;
               m_ff      <= {15'd0, rms1};
               n_ff      <= 5'd16;
            end else begin
               sat_ff  <= lg >= lb_ff;
               qrem_ff <= {1'b0, lg};
               q_ff    <= '0;
               cnt_ff  <= STEP_W'(QDIV_STEPS - 1);
            end
         end
         // ratio of logs, 16 quotient bits
         L_QDIV: begin
            qrem_ff <= qd_ge ? (qd_t - {1'b0, lb_ff}) : qd_t;
            q_ff    <= {q_ff[14:0], qd_ge};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ----- design/stereo_rms_level_meter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_top
// Stereo RMS meter: accumulates squared samples per block, then maps each
// channel to a log-scaled bar length with peak hold and decay.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// req_*     in   tdata: left_sample[15:0], right_sample[31:16]; tlast: last_frame
// rsp_*     out  tdata: bar_left[5:0], bar_right[11:6], zero pad [15:12]
// csr_*     in   index 0 full_scale_rms, 1 decay_factor, 2 bar_max
//
// A frame without tlast is summed, up to 4096 frames per block, and the next
// may follow at once. A last frame holds req_tready low while the shared
// level unit runs twice (43-step divide, 16-step root, two logs of up to 47
// steps each, 16-step ratio divide) and until the result is loaded. Reset is
// synchronous; it clears sums and levels and loads register defaults. A result
// waits in the output register until taken; new frames are taken meanwhile.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // left_sample, right_sample
   input  wire logic        req_tlast,   // last_frame
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // bar_left, bar_right, pad
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import srlm_pkg::*;

   top_state_type state_ff, state_in;

   logic [15:0]       fs_ff, decay_ff;
   logic [5:0]        barmax_ff;
   logic [SUM_W-1:0]  sum_l_ff, sum_r_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DISP_W-1:0] disp_l_ff, disp_r_ff;
   logic              rsp_valid_ff;
   logic [11:0]       rsp_data_ff;

   logic              req_fire, lvl_start, lvl_done, side, emit_load;
   logic signed [15:0] smp_l, smp_r;
   logic signed [31:0] sq_l, sq_r;
   logic [DISP_W-1:0] lvl_disp;
   logic [22:0]       bar_l_prod, bar_r_prod;

   assign req_fire = req_tvalid && req_tready;
   assign smp_l    = req_tdata[15:0];
   assign smp_r    = req_tdata[31:16];
   assign sq_l     = smp_l * smp_l;
   assign sq_r     = smp_r * smp_r;
   assign side     = (state_ff == T_START_R) || (state_ff == T_WAIT_R);
   assign bar_l_prod = disp_l_ff * barmax_ff;
   assign bar_r_prod = disp_r_ff * barmax_ff;

   // shared level unit, run once per channel
   srlm_level u_level (
      .clock      (clock),
      .reset      (reset),
      .start      (lvl_start),
      .sum        (side ? sum_r_ff : sum_l_ff),
      .count      (count_ff),
      .full_scale (fs_ff),
      .decay      (decay_ff),
      .disp_in    (side ? disp_r_ff : disp_l_ff),
      .done       (lvl_done),
      .disp_out   (lvl_disp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE:    if (req_fire && req_tlast) state_in = T_START_L;
         T_START_L: state_in = T_WAIT_L;
         T_WAIT_L:  if (lvl_done) state_in = T_START_R;
         T_START_R: state_in = T_WAIT_R;
         T_WAIT_R:  if (lvl_done) state_in = T_EMIT;
         T_EMIT:    if (emit_load) state_in = T_IDLE;
         default:   state_in = T_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = (state_ff == T_IDLE);
      lvl_start  = (state_ff == T_START_L) || (state_ff == T_START_R);
      emit_load  = (state_ff == T_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= T_IDLE;
      else       state_ff <= state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff     <= FULL_SCALE_RESET;
         decay_ff  <= DECAY_RESET;
         barmax_ff <= BAR_MAX_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FULL_SCALE: fs_ff     <= csr_wdata;
            CSR_DECAY:      decay_ff  <= csr_wdata;
            CSR_BAR_MAX:    barmax_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // accumulation, cleared when the result is loaded
   always_ff @(posedge clock) begin
      if (reset || emit_load) begin
         sum_l_ff <= '0;
         sum_r_ff <= '0;
         count_ff <= '0;
      end else if (req_fire && count_ff < CNT_W'(MAX_FRAMES)) begin
         sum_l_ff <= sum_l_ff + SUM_W'($unsigned(sq_l));
         sum_r_ff <= sum_r_ff + SUM_W'($unsigned(sq_r));
         count_ff <= count_ff + 1'b1;
      end
   end

   // held display levels
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_l_ff <= '0;
         disp_r_ff <= '0;
      end else if (lvl_done && state_ff == T_WAIT_L) begin
         disp_l_ff <= lvl_disp;
      end else if (lvl_done && state_ff == T_WAIT_R) begin
         disp_r_ff <= lvl_disp;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_load) rsp_data_ff <= {bar_r_prod[21:16], bar_l_prod[21:16]};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   // checks
`include "assert_macros.svh"
   `ASSERT_IMPL(a_done_in_wait, lvl_done, (state_ff == T_WAIT_L || state_ff == T_WAIT_R))
   `ASSERT_NEXT(a_load_valid, emit_load, rsp_tvalid)
   `ASSERT_NEXT(a_last_starts, (req_fire && req_tlast), (state_ff == T_START_L))

endmodule
`default_nettype wire
